// ----- design/circle_through_three_points_core_defines.svh -----
// ----------------------------------------------------------------------------
// Circle through three points: assertion macros
// Concurrent checks used by the core; compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_THROUGH_THREE_POINTS_CORE_DEFINES_SVH
`define CIRCLE_THROUGH_THREE_POINTS_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define CIRC3_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define CIRC3_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CIRC3_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define CIRC3_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- design/circ3_pkg.sv -----
// ----------------------------------------------------------------------------
// Circle through three points: package
// Shared constants and types of the circumcircle core.
// ----------------------------------------------------------------------------
package circ3_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 4;

   localparam int CENTER_W = 24;
   localparam int RADIUS_W = 23;

   localparam logic signed [CENTER_W-1:0] CMAX = 24'sh7FFFFF;
   localparam logic signed [CENTER_W-1:0] CMIN = 24'sh800000;
   localparam logic [RADIUS_W-1:0]        RMAX = 23'h7FFFFF;

   localparam int DX_W      = 32;
   localparam int SQRT_W    = 32;
   localparam int SQRT_VW   = 2 * SQRT_W;
   localparam int SQRT_RMW  = SQRT_W + 3;

   typedef struct packed {
      logic signed [CENTER_W-1:0] cx;
      logic signed [CENTER_W-1:0] cy;
      logic                       sat;
      logic                       big;
      logic                       ok;
   } circ3_side_type;

endpackage

// ----- design/circ3_ifs.sv -----
// ----------------------------------------------------------------------------
// Circle through three points: channel interfaces
// Valid/ready channels for point triples and circle results.
// ----------------------------------------------------------------------------
interface circ3_req_if #(
   parameter int COORD_BITS = circ3_pkg::COORD_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] point_a_x;
   logic [COORD_BITS-1:0] point_a_y;
   logic [COORD_BITS-1:0] point_b_x;
   logic [COORD_BITS-1:0] point_b_y;
   logic [COORD_BITS-1:0] point_c_x;
   logic [COORD_BITS-1:0] point_c_y;

   modport source (
      output valid, point_a_x, point_a_y, point_b_x, point_b_y, point_c_x, point_c_y,
      input  ready
   );
   modport sink (
      input  valid, point_a_x, point_a_y, point_b_x, point_b_y, point_c_x, point_c_y,
      output ready
   );
endinterface

interface circ3_rsp_if ();
   import circ3_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [CENTER_W-1:0] center_x;
   logic signed [CENTER_W-1:0] center_y;
   logic [RADIUS_W-1:0]        radius;
   logic                       valid_res;
   logic                       saturated;

   modport source (
      output valid, center_x, center_y, radius, valid_res, saturated,
      input  ready
   );
   modport sink (
      input  valid, center_x, center_y, radius, valid_res, saturated,
      output ready
   );
endinterface

// ----- design/circ3_div_cell.sv -----
// ----------------------------------------------------------------------------
// Circle through three points: divider cell
// One restoring quotient bit for the x and y lanes, sharing one divisor.
// ----------------------------------------------------------------------------
module circ3_div_cell #(
   parameter int NW  = 48,
   parameter int DVW = 29,
   parameter int SBW = 27
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_vld,
   input  logic [DVW+NW-1:0]  in_acc_x,
   input  logic [DVW+NW-1:0]  in_acc_y,
   input  logic [DVW-1:0]     in_div,
   input  logic [SBW-1:0]     in_side,
   output logic               out_vld,
   output logic [DVW+NW-1:0]  out_acc_x,
   output logic [DVW+NW-1:0]  out_acc_y,
   output logic [DVW-1:0]     out_div,
   output logic [SBW-1:0]     out_side
);

   function automatic logic [DVW+NW-1:0] div_step(input logic [DVW+NW-1:0] acc,
                                                  input logic [DVW-1:0] dv);
      logic [DVW:0]   top;
      logic [DVW:0]   diff;
      logic           ge;
      logic [DVW-1:0] rem;
      top  = {acc[DVW+NW-1:NW], acc[NW-1]};
      diff = top - {1'b0, dv};
      ge   = ~diff[DVW];
      rem  = ge ? diff[DVW-1:0] : top[DVW-1:0];
      return {rem, acc[NW-2:0], ge};
   endfunction

   logic              vld_ff;
   logic [DVW+NW-1:0] accx_ff, accy_ff, accx_in, accy_in;
   logic [DVW-1:0]    div_ff;
   logic [SBW-1:0]    side_ff;

   assign accx_in = div_step(in_acc_x, in_div);
   assign accy_in = div_step(in_acc_y, in_div);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         accx_ff <= accx_in;
         accy_ff <= accy_in;
         div_ff  <= in_div;
         side_ff <= in_side;
      end
   end

   assign out_vld   = vld_ff;
   assign out_acc_x = accx_ff;
   assign out_acc_y = accy_ff;
   assign out_div   = div_ff;
   assign out_side  = side_ff;

endmodule

// ----- design/circ3_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Circle through three points: square root cell
// One root bit of the digit recurrence, two radicand bits consumed.
// ----------------------------------------------------------------------------
module circ3_sqrt_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_vld,
   input  logic [circ3_pkg::SQRT_RMW-1:0] in_rem,
   input  logic [circ3_pkg::SQRT_W-1:0]   in_root,
   input  logic [circ3_pkg::SQRT_VW-1:0]  in_v,
   input  circ3_pkg::circ3_side_type     in_side,
   output logic                          out_vld,
   output logic [circ3_pkg::SQRT_RMW-1:0] out_rem,
   output logic [circ3_pkg::SQRT_W-1:0]   out_root,
   output logic [circ3_pkg::SQRT_VW-1:0]  out_v,
   output circ3_pkg::circ3_side_type     out_side
);
   import circ3_pkg::*;

   logic                vld_ff;
   logic [SQRT_RMW-1:0] rem_ff, rem_in;
   logic [SQRT_W-1:0]   root_ff, root_in;
   logic [SQRT_VW-1:0]  v_ff;
   circ3_side_type      side_ff;
   logic [SQRT_RMW-1:0] shifted, trial;
   logic                ge;

   assign shifted = {in_rem[SQRT_RMW-3:0], in_v[SQRT_VW-1:SQRT_VW-2]};
   assign trial   = SQRT_RMW'({in_root, 2'b01});
   assign ge      = shifted >= trial;
   assign rem_in  = ge ? shifted - trial : shifted;
   assign root_in = {in_root[SQRT_W-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         v_ff    <= {in_v[SQRT_VW-3:0], 2'b00};
         side_ff <= in_side;
      end
   end

   assign out_vld  = vld_ff;
   assign out_rem  = rem_ff;
   assign out_root = root_ff;
   assign out_v    = v_ff;
   assign out_side = side_ff;

endmodule

// ----- design/circle_through_three_points_core.sv -----
// ----------------------------------------------------------------------------
// Circle through three points: core
// Circumcircle center and radius of a point triple, fixed point output.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one point triple per item (valid/ready). rsp_ch returns one
//   item per triple: center_x/center_y/radius in sixteenths of a pixel (at the
//   default FRAC_BITS), valid_res low for collinear points, saturated high
//   when a field was clipped.
//   Throughput: one item per cycle while rsp_ch does not stall. Items pass the
//   divider cell chain, one quotient bit per cell, and the 32-cell square
//   root chain, one root bit per cell.
//   Items leave in order. When rsp_ch stalls with a result held in the output
//   register, the whole chain holds and req_ch.ready drops; empty slots do not
//   need to drain.
//   Reset clears every valid bit; nothing else needs a reset sequence.
// ----------------------------------------------------------------------------
`include "circle_through_three_points_core_defines.svh"

module circle_through_three_points_core #(
   parameter int COORD_BITS = circ3_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = circ3_pkg::FRAC_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   circ3_req_if.sink   req_ch,
   circ3_rsp_if.source rsp_ch
);
   import circ3_pkg::*;

   localparam int CW   = COORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int DFW  = CW + 1;
   localparam int PW   = 2 * DFW;
   localparam int DS   = PW + 2;
   localparam int SW   = PW;
   localparam int MPW  = DFW + SW;
   localparam int NXW  = MPW + 1;
   localparam int AXD  = CW + 1 + DS;
   localparam int TW   = 3 * CW + 6 + F;
   localparam int NW   = TW + 2;
   localparam int DVW  = DS + 1;
   localparam int RW   = NW + 1;
   localparam int EW   = (NW + 3 > 34) ? NW + 3 : 34;
   localparam int SBW  = 2 * CW + 3;

   localparam logic signed [EW-1:0] DX_HI = EW'(64'sd2147483648);
   localparam logic signed [EW-1:0] DX_LO = -DX_HI;
   localparam logic signed [EW-1:0] CMAX_E = EW'(CMAX);
   localparam logic signed [EW-1:0] CMIN_E = EW'(CMIN);

   logic adv;
   logic rsp_vld_ff;

   assign adv          = ~rsp_vld_ff | rsp_ch.ready;
   assign req_ch.ready = adv;

   // differences relative to A
   logic                  a_vld_ff;
   logic [CW-1:0]         a_ax_ff, a_ay_ff;
   logic signed [DFW-1:0] a_bx_ff, a_by_ff, a_cx_ff, a_cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ax_ff <= req_ch.point_a_x;
         a_ay_ff <= req_ch.point_a_y;
         a_bx_ff <= $signed({1'b0, req_ch.point_b_x}) - $signed({1'b0, req_ch.point_a_x});
         a_by_ff <= $signed({1'b0, req_ch.point_b_y}) - $signed({1'b0, req_ch.point_a_y});
         a_cx_ff <= $signed({1'b0, req_ch.point_c_x}) - $signed({1'b0, req_ch.point_a_x});
         a_cy_ff <= $signed({1'b0, req_ch.point_c_y}) - $signed({1'b0, req_ch.point_a_y});
      end
   end

   // first products
   logic                  b_vld_ff;
   logic [CW-1:0]         b_ax_ff, b_ay_ff;
   logic signed [DFW-1:0] b_bx_ff, b_by_ff, b_cx_ff, b_cy_ff;
   logic signed [PW-1:0]  b_bxcy_ff, b_bycx_ff, b_bxbx_ff, b_byby_ff, b_cxcx_ff, b_cycy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_ax_ff   <= a_ax_ff;
         b_ay_ff   <= a_ay_ff;
         b_bx_ff   <= a_bx_ff;
         b_by_ff   <= a_by_ff;
         b_cx_ff   <= a_cx_ff;
         b_cy_ff   <= a_cy_ff;
         b_bxcy_ff <= PW'(a_bx_ff) * PW'(a_cy_ff);
         b_bycx_ff <= PW'(a_by_ff) * PW'(a_cx_ff);
         b_bxbx_ff <= PW'(a_bx_ff) * PW'(a_bx_ff);
         b_byby_ff <= PW'(a_by_ff) * PW'(a_by_ff);
         b_cxcx_ff <= PW'(a_cx_ff) * PW'(a_cx_ff);
         b_cycy_ff <= PW'(a_cy_ff) * PW'(a_cy_ff);
      end
   end

   // determinant and squared lengths
   logic                  c_vld_ff;
   logic [CW-1:0]         c_ax_ff, c_ay_ff;
   logic signed [DFW-1:0] c_bx_ff, c_by_ff, c_cx_ff, c_cy_ff;
   logic signed [DS-1:0]  c_d_ff;
   logic signed [SW-1:0]  c_sb_ff, c_sc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ax_ff <= b_ax_ff;
         c_ay_ff <= b_ay_ff;
         c_bx_ff <= b_bx_ff;
         c_by_ff <= b_by_ff;
         c_cx_ff <= b_cx_ff;
         c_cy_ff <= b_cy_ff;
         c_d_ff  <= (DS'(b_bxcy_ff) - DS'(b_bycx_ff)) <<< 1;
         c_sb_ff <= b_bxbx_ff + b_byby_ff;
         c_sc_ff <= b_cxcx_ff + b_cycy_ff;
      end
   end

   // numerator products
   logic                  d_vld_ff;
   logic [CW-1:0]         d_ax_ff, d_ay_ff;
   logic signed [DS-1:0]  d_d_ff;
   logic signed [MPW-1:0] d_cysb_ff, d_bysc_ff, d_bxsc_ff, d_cxsb_ff;
   logic signed [AXD-1:0] d_axd_ff, d_ayd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ax_ff   <= c_ax_ff;
         d_ay_ff   <= c_ay_ff;
         d_d_ff    <= c_d_ff;
         d_cysb_ff <= MPW'(c_cy_ff) * MPW'(c_sb_ff);
         d_bysc_ff <= MPW'(c_by_ff) * MPW'(c_sc_ff);
         d_bxsc_ff <= MPW'(c_bx_ff) * MPW'(c_sc_ff);
         d_cxsb_ff <= MPW'(c_cx_ff) * MPW'(c_sb_ff);
         d_axd_ff  <= AXD'($signed({1'b0, c_ax_ff})) * AXD'(c_d_ff);
         d_ayd_ff  <= AXD'($signed({1'b0, c_ay_ff})) * AXD'(c_d_ff);
      end
   end

   // numerators, divisor sign folded in
   logic                  e_vld_ff, e_neg_ff, e_ok_ff;
   logic [CW-1:0]         e_ax_ff, e_ay_ff;
   logic [DS-1:0]         e_dabs_ff;
   logic signed [NXW-1:0] e_nx_ff, e_ny_ff;
   logic signed [AXD-1:0] e_axd_ff, e_ayd_ff;
   logic                  d_neg;

   assign d_neg = d_d_ff[DS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_ax_ff   <= d_ax_ff;
         e_ay_ff   <= d_ay_ff;
         e_neg_ff  <= d_neg;
         e_ok_ff   <= d_d_ff != '0;
         e_dabs_ff <= d_neg ? DS'(-d_d_ff) : DS'(d_d_ff);
         e_nx_ff   <= NXW'(d_cysb_ff) - NXW'(d_bysc_ff);
         e_ny_ff   <= NXW'(d_bxsc_ff) - NXW'(d_cxsb_ff);
         e_axd_ff  <= d_neg ? -d_axd_ff : d_axd_ff;
         e_ayd_ff  <= d_neg ? -d_ayd_ff : d_ayd_ff;
      end
   end

   // scaled center numerators
   logic                 f_vld_ff, f_ok_ff;
   logic [CW-1:0]        f_ax_ff, f_ay_ff;
   logic [DS-1:0]        f_dabs_ff;
   logic signed [TW-1:0] f_tx_ff, f_ty_ff, f_nxs, f_nys;

   assign f_nxs = e_neg_ff ? -TW'(e_nx_ff) : TW'(e_nx_ff);
   assign f_nys = e_neg_ff ? -TW'(e_ny_ff) : TW'(e_ny_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ax_ff   <= e_ax_ff;
         f_ay_ff   <= e_ay_ff;
         f_ok_ff   <= e_ok_ff;
         f_dabs_ff <= e_dabs_ff;
         f_tx_ff   <= (f_nxs + TW'(e_axd_ff)) <<< F;
         f_ty_ff   <= (f_nys + TW'(e_ayd_ff)) <<< F;
      end
   end

   // rounding dividend and divisor
   logic           g_vld_ff, g_ok_ff, g_sx_ff, g_sy_ff;
   logic [CW-1:0]  g_ax_ff, g_ay_ff;
   logic [NW-1:0]  g_numx_ff, g_numy_ff;
   logic [DVW-1:0] g_div_ff;
   logic [TW-1:0]  g_magx, g_magy;

   assign g_magx = f_tx_ff[TW-1] ? TW'(-f_tx_ff) : TW'(f_tx_ff);
   assign g_magy = f_ty_ff[TW-1] ? TW'(-f_ty_ff) : TW'(f_ty_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (adv) begin
         g_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_ax_ff   <= f_ax_ff;
         g_ay_ff   <= f_ay_ff;
         g_ok_ff   <= f_ok_ff;
         g_sx_ff   <= f_tx_ff[TW-1];
         g_sy_ff   <= f_ty_ff[TW-1];
         g_numx_ff <= (NW'(g_magx) << 1) + NW'(f_dabs_ff);
         g_numy_ff <= (NW'(g_magy) << 1) + NW'(f_dabs_ff);
         g_div_ff  <= {f_dabs_ff, 1'b0};
      end
   end

   // divider chain, one quotient bit per cell
   logic              dv_vld  [NW+1];
   logic [DVW+NW-1:0] dv_accx [NW+1];
   logic [DVW+NW-1:0] dv_accy [NW+1];
   logic [DVW-1:0]    dv_div  [NW+1];
   logic [SBW-1:0]    dv_side [NW+1];

   assign dv_vld[0]  = g_vld_ff;
   assign dv_accx[0] = {{DVW{1'b0}}, g_numx_ff};
   assign dv_accy[0] = {{DVW{1'b0}}, g_numy_ff};
   assign dv_div[0]  = g_div_ff;
   assign dv_side[0] = {g_ax_ff, g_ay_ff, g_sx_ff, g_sy_ff, g_ok_ff};

   for (genvar k = 0; k < NW; k++) begin : g_div
      circ3_div_cell #(
         .NW  (NW),
         .DVW (DVW),
         .SBW (SBW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (adv),
         .in_vld    (dv_vld[k]),
         .in_acc_x  (dv_accx[k]),
         .in_acc_y  (dv_accy[k]),
         .in_div    (dv_div[k]),
         .in_side   (dv_side[k]),
         .out_vld   (dv_vld[k+1]),
         .out_acc_x (dv_accx[k+1]),
         .out_acc_y (dv_accy[k+1]),
         .out_div   (dv_div[k+1]),
         .out_side  (dv_side[k+1])
      );
   end

   // signed rounded center
   logic                 h_vld_ff, h_ok_ff;
   logic [CW-1:0]        h_ax_ff, h_ay_ff;
   logic signed [RW-1:0] h_rx_ff, h_ry_ff;
   logic [CW-1:0]        q_ax, q_ay;
   logic                 q_sx, q_sy, q_ok;
   logic signed [RW-1:0] q_x, q_y;

   assign {q_ax, q_ay, q_sx, q_sy, q_ok} = dv_side[NW];
   assign q_x = $signed({1'b0, dv_accx[NW][NW-1:0]});
   assign q_y = $signed({1'b0, dv_accy[NW][NW-1:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else if (adv) begin
         h_vld_ff <= dv_vld[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_ax_ff <= q_ax;
         h_ay_ff <= q_ay;
         h_ok_ff <= q_ok;
         h_rx_ff <= q_sx ? -q_x : q_x;
         h_ry_ff <= q_sy ? -q_y : q_y;
      end
   end

   // offset to A, range checks and center clipping
   logic                    i_vld_ff;
   circ3_side_type          i_side_ff;
   logic signed [DX_W-1:0]  i_dx_ff, i_dy_ff;
   logic signed [EW-1:0]    i_rx, i_ry, i_dx, i_dy;
   logic                    i_big;

   assign i_rx  = EW'(h_rx_ff);
   assign i_ry  = EW'(h_ry_ff);
   assign i_dx  = i_rx - (EW'($signed({1'b0, h_ax_ff})) <<< F);
   assign i_dy  = i_ry - (EW'($signed({1'b0, h_ay_ff})) <<< F);
   assign i_big = (i_dx >= DX_HI) || (i_dx <= DX_LO) || (i_dy >= DX_HI) || (i_dy <= DX_LO);

   always_ff @(posedge clock) begin
      if (reset) begin
         i_vld_ff <= 1'b0;
      end else if (adv) begin
         i_vld_ff <= h_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i_dx_ff       <= i_dx[DX_W-1:0];
         i_dy_ff       <= i_dy[DX_W-1:0];
         i_side_ff.cx  <= (i_rx > CMAX_E) ? CMAX : (i_rx < CMIN_E) ? CMIN : i_rx[CENTER_W-1:0];
         i_side_ff.cy  <= (i_ry > CMAX_E) ? CMAX : (i_ry < CMIN_E) ? CMIN : i_ry[CENTER_W-1:0];
         i_side_ff.sat <= (i_rx > CMAX_E) || (i_rx < CMIN_E) ||
                          (i_ry > CMAX_E) || (i_ry < CMIN_E);
         i_side_ff.big <= i_big;
         i_side_ff.ok  <= h_ok_ff;
      end
   end

   // squares
   logic                      j_vld_ff;
   circ3_side_type            j_side_ff;
   logic signed [SQRT_VW-1:0] j_sqx_ff, j_sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         j_vld_ff <= 1'b0;
      end else if (adv) begin
         j_vld_ff <= i_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         j_side_ff <= i_side_ff;
         j_sqx_ff  <= SQRT_VW'(i_dx_ff) * SQRT_VW'(i_dx_ff);
         j_sqy_ff  <= SQRT_VW'(i_dy_ff) * SQRT_VW'(i_dy_ff);
      end
   end

   // squared radius
   logic               k_vld_ff;
   circ3_side_type     k_side_ff;
   logic [SQRT_VW-1:0] k_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_vld_ff <= 1'b0;
      end else if (adv) begin
         k_vld_ff <= j_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         k_side_ff <= j_side_ff;
         k_v_ff    <= SQRT_VW'(j_sqx_ff) + SQRT_VW'(j_sqy_ff);
      end
   end

   // square root chain, one root bit per cell
   logic                sq_vld  [SQRT_W+1];
   logic [SQRT_RMW-1:0] sq_rem  [SQRT_W+1];
   logic [SQRT_W-1:0]   sq_root [SQRT_W+1];
   logic [SQRT_VW-1:0]  sq_v    [SQRT_W+1];
   circ3_side_type      sq_side [SQRT_W+1];

   assign sq_vld[0]  = k_vld_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_v[0]    = k_v_ff;
   assign sq_side[0] = k_side_ff;

   for (genvar k = 0; k < SQRT_W; k++) begin : g_sqrt
      circ3_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (adv),
         .in_vld   (sq_vld[k]),
         .in_rem   (sq_rem[k]),
         .in_root  (sq_root[k]),
         .in_v     (sq_v[k]),
         .in_side  (sq_side[k]),
         .out_vld  (sq_vld[k+1]),
         .out_rem  (sq_rem[k+1]),
         .out_root (sq_root[k+1]),
         .out_v    (sq_v[k+1]),
         .out_side (sq_side[k+1])
      );
   end

   // output register
   logic signed [CENTER_W-1:0] rsp_cx_ff, rsp_cy_ff;
   logic [RADIUS_W-1:0]        rsp_rad_ff;
   logic                       rsp_ok_ff, rsp_sat_ff;
   circ3_side_type             o_side;
   logic                       o_over;

   assign o_side = sq_side[SQRT_W];
   assign o_over = o_side.big || (sq_root[SQRT_W] > SQRT_W'(RMAX));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= sq_vld[SQRT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (o_side.ok) begin
            rsp_cx_ff  <= o_side.cx;
            rsp_cy_ff  <= o_side.cy;
            rsp_rad_ff <= o_over ? RMAX : sq_root[SQRT_W][RADIUS_W-1:0];
            rsp_ok_ff  <= 1'b1;
            rsp_sat_ff <= o_side.sat || o_over;
         end else begin
            rsp_cx_ff  <= '0;
            rsp_cy_ff  <= '0;
            rsp_rad_ff <= '0;
            rsp_ok_ff  <= 1'b0;
            rsp_sat_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid     = rsp_vld_ff;
   assign rsp_ch.center_x  = rsp_cx_ff;
   assign rsp_ch.center_y  = rsp_cy_ff;
   assign rsp_ch.radius    = rsp_rad_ff;
   assign rsp_ch.valid_res = rsp_ok_ff;
   assign rsp_ch.saturated = rsp_sat_ff;

   `CIRC3_ASSERT_IMPLY(a_no_circle_zero, clock, reset,
      rsp_ch.valid && !rsp_ch.valid_res,
      rsp_ch.center_x == 0 && rsp_ch.center_y == 0 && rsp_ch.radius == 0 && !rsp_ch.saturated,
      "collinear item carries nonzero fields")
   `CIRC3_ASSERT_IMPLY(a_sat_needs_circle, clock, reset,
      rsp_ch.valid && rsp_ch.saturated, rsp_ch.valid_res,
      "saturation flagged without a circle")
   `CIRC3_ASSERT_IMPLY(a_stall_blocks_input, clock, reset,
      rsp_ch.valid && !rsp_ch.ready, !req_ch.ready,
      "input accepted while the chain is stalled")

endmodule

// ----- dv/circ3_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circumcircle result checker
// Watches both channels, predicts the circle of each accepted point triple
// and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module circ3_checker
   import circ3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   circ3_req_if.sink   req_mon,
   circ3_rsp_if.sink   rsp_mon,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic signed [CENTER_W-1:0] center_x;
      logic signed [CENTER_W-1:0] center_y;
      logic [RADIUS_W-1:0]        radius;
      logic                       valid_res;
      logic                       saturated;
   } circle_type;

   circle_type circle_q[$];

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root, bit_val;
      root = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > v) bit_val >>= 2;
      while (bit_val != 0) begin
         if (v >= root + bit_val) begin
            v -= root + bit_val;
            root = (root >> 1) + bit_val;
         end else begin
            root >>= 1;
         end
         bit_val >>= 2;
      end
      return root;
   endfunction

   function automatic longint round_div(longint t, longint d);
      longint unsigned mag, q;
      mag = (t < 0) ? -t : t;
      q = (2 * mag + d) / (2 * d);
      return (t < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp_center(longint v, ref logic sat);
      if (v > 64'sd8388607) begin
         sat = 1'b1;
         return 64'sd8388607;
      end
      if (v < -64'sd8388608) begin
         sat = 1'b1;
         return -64'sd8388608;
      end
      return v;
   endfunction

   function automatic circle_type circumcircle(longint ax, longint ay, longint pbx,
                                               longint pby, longint pcx, longint pcy);
      circle_type res;
      longint bx, by, cx, cy, d, sb, sc, nx, ny, rx, ry, dx, dy;
      longint unsigned r;
      logic sat;
      res = '0;
      sat = 1'b0;
      bx = pbx - ax;
      by = pby - ay;
      cx = pcx - ax;
      cy = pcy - ay;
      d = 2 * (bx * cy - by * cx);
      if (d == 0) return res;
      sb = bx * bx + by * by;
      sc = cx * cx + cy * cy;
      nx = cy * sb - by * sc;
      ny = bx * sc - cx * sb;
      if (d < 0) begin
         d = -d;
         nx = -nx;
         ny = -ny;
      end
      rx = round_div(ax * d * 16 + nx * 16, d);
      ry = round_div(ay * d * 16 + ny * 16, d);
      dx = rx - ax * 16;
      dy = ry - ay * 16;
      if (dx >= (64'sd1 <<< 31) || dx <= -(64'sd1 <<< 31) ||
          dy >= (64'sd1 <<< 31) || dy <= -(64'sd1 <<< 31)) begin
         r = RMAX;
         sat = 1'b1;
      end else begin
         r = floor_sqrt(longint'(dx * dx) + longint'(dy * dy));
         if (r > RMAX) begin
            r = RMAX;
            sat = 1'b1;
         end
      end
      rx = clamp_center(rx, sat);
      ry = clamp_center(ry, sat);
      res.center_x = rx[CENTER_W-1:0];
      res.center_y = ry[CENTER_W-1:0];
      res.radius = r[RADIUS_W-1:0];
      res.valid_res = 1'b1;
      res.saturated = sat;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      circle_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            circle_q.insert(circle_q.size(), circumcircle(req_mon.point_a_x,
               req_mon.point_a_y, req_mon.point_b_x, req_mon.point_b_y,
               req_mon.point_c_x, req_mon.point_c_y));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (circle_q.size() == 0) begin
               report_mismatch("unexpected item", 1, 0);
            end else begin
               want = circle_q.pop_front();
               if (rsp_mon.center_x !== want.center_x)
                  report_mismatch("center_x", rsp_mon.center_x, want.center_x);
               if (rsp_mon.center_y !== want.center_y)
                  report_mismatch("center_y", rsp_mon.center_y, want.center_y);
               if (rsp_mon.radius !== want.radius)
                  report_mismatch("radius", rsp_mon.radius, want.radius);
               if (rsp_mon.valid_res !== want.valid_res)
                  report_mismatch("valid_res", rsp_mon.valid_res, want.valid_res);
               if (rsp_mon.saturated !== want.saturated)
                  report_mismatch("saturated", rsp_mon.saturated, want.saturated);
            end
         end
      end
      pending = circle_q.size();
   end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circumcircle core testbench
// Drives directed and random point triples with random gaps and output
// stalls, including a long stall and a full drain, and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import circ3_pkg::*;

   localparam int LATENCY = 3 * COORD_BITS_DEF + FRAC_BITS_DEF + 52;
   localparam int LIMIT   = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending, cycle_count = 0;
   bit   long_hold = 1'b0;

   circ3_req_if req_ch ();
   circ3_rsp_if rsp_ch ();

   circle_through_three_points_core dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch));

   circ3_checker checker_i (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .fail_count(fail_count), .pending(pending));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver: random stalls, one long hold-off
   initial begin
      int n;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (3 * LATENCY) @(posedge clock);
            long_hold = 1'b0;
         end
         n = gap_len();
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_triple(logic [11:0] ax, logic [11:0] ay, logic [11:0] bx,
                              logic [11:0] by, logic [11:0] cx, logic [11:0] cy);
      req_ch.valid     <= 1'b1;
      req_ch.point_a_x <= ax;
      req_ch.point_a_y <= ay;
      req_ch.point_b_x <= bx;
      req_ch.point_b_y <= by;
      req_ch.point_c_x <= cx;
      req_ch.point_c_y <= cy;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random(bit gaps);
      int n, mode;
      logic [11:0] p[6];
      n = gaps ? gap_len() : 0;
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      mode = $urandom_range(0, 9);
      foreach (p[i]) p[i] = 12'($urandom_range(0, 4095));
      if (mode == 0) begin
         p[2] = p[0] + 12'($urandom_range(0, 3));
         p[3] = p[1] + 12'($urandom_range(0, 3));
         p[4] = 12'(p[0] + 2 * (p[2] - p[0]));
         p[5] = 12'(p[1] + 2 * (p[3] - p[1]));
      end else if (mode == 1) begin
         p[2] = p[0] + 12'($urandom_range(0, 2));
         p[3] = p[1] + 12'($urandom_range(0, 2));
         p[4] = p[0] + 12'($urandom_range(0, 4));
         p[5] = p[1] + 12'($urandom_range(0, 4));
      end else if (mode == 2) begin
         p[2] = p[0] + 12'($urandom_range(0, 40));
         p[3] = p[1] + 12'($urandom_range(0, 40));
         p[4] = p[0] + 12'($urandom_range(0, 40));
         p[5] = p[1] + 12'($urandom_range(0, 40));
      end
      send_triple(p[0], p[1], p[2], p[3], p[4], p[5]);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.point_a_x = '0;
      req_ch.point_a_y = '0;
      req_ch.point_b_x = '0;
      req_ch.point_b_y = '0;
      req_ch.point_c_x = '0;
      req_ch.point_c_y = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_triple(0, 0, 0, 0, 0, 0);
      send_triple(4095, 4095, 4095, 4095, 4095, 4095);
      send_triple(0, 0, 4095, 4095, 2000, 2000);
      send_triple(0, 0, 4095, 0, 0, 4095);
      send_triple(4095, 4095, 0, 4095, 4095, 0);
      send_triple(0, 0, 1, 0, 0, 1);
      send_triple(0, 0, 1, 1, 2, 0);
      send_triple(0, 0, 4095, 1, 2047, 1);
      send_triple(0, 0, 4095, 0, 2048, 1);
      send_triple(0, 4095, 4095, 4094, 2048, 4094);
      send_triple(100, 100, 102, 100, 101, 101);
      send_triple(0, 0, 3, 0, 0, 1);
      send_triple(5, 0, 0, 5, 4095, 4095);
      send_triple(2048, 2048, 2049, 2048, 2048, 2049);
      send_triple(4095, 0, 0, 0, 2047, 1);
      send_triple(1, 0, 0, 1, 3, 3);
      drain();

      long_hold = 1'b1;
      repeat (300) send_random(1'b0);
      repeat (200) send_random(1'b1);
      drain();
      repeat (300) send_random(1'b1);
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/circ3_pkg.sv
design/circ3_ifs.sv
design/circ3_div_cell.sv
design/circ3_sqrt_cell.sv
design/circle_through_three_points_core.sv
dv/circ3_checker.sv
dv/testbench.sv
